@@ sv/ring_queue_with_key_search_assert.svh @@
// ----------------------------------------------------------------------------
// ring_queue_with_key_search_assert.svh
// Assertion macros shared by the ring queue RTL; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef RING_QUEUE_WITH_KEY_SEARCH_ASSERT_SVH
`define RING_QUEUE_WITH_KEY_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS
// Property must hold at every clock edge outside reset.
`define RQKS_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rqks assertion failed");
// Condition must never be true outside reset.
`define RQKS_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rqks forbidden condition seen");
`else
`define RQKS_ASSERT(label, clk, rst, prop)
`define RQKS_NEVER(label, clk, rst, cond)
`endif

`endif

@@ sv/rqks_pkg.sv @@
// ----------------------------------------------------------------------------
// rqks_pkg
// Types, codes and widths shared by the ring queue with key search.
// ----------------------------------------------------------------------------
package rqks_pkg;

  // Field widths
  localparam int KEY_W      = 32;
  localparam int PAYLOAD_W  = 64;
  localparam int OCC_W      = 7;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;

  // Stream data widths, padded to whole bytes
  localparam int S_TDATA_W  = 96;
  localparam int M_TDATA_W  = 104;

  localparam int QUEUE_DEPTH_DEFAULT = 128;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQUEUE = 2'd0,
    ACT_DEQUEUE = 2'd1,
    ACT_SEARCH  = 2'd2,
    ACT_NOP     = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_FULL      = 2'd1,
    STATUS_EMPTY     = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DEQ_DATA,
    ST_SCAN,
    ST_RESP
  } state_t;

  typedef struct packed {
    status_t                     status;
    logic signed [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0]        payload;
    logic [OCC_W-1:0]            occupancy;
  } result_t;

endpackage

@@ sv/ring_queue_with_key_search.sv @@
// ----------------------------------------------------------------------------
// ring_queue_with_key_search
// Circular queue of key/payload records with enqueue, dequeue and search.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one action per transaction: tuser selects enqueue,
//   dequeue, search or no-op; tdata carries the key and payload. Every
//   transaction returns exactly one result transaction on the master stream
//   with status in tuser and key, payload and occupancy in tdata.
//   The queue holds at most QUEUE_DEPTH-1 records. Records sit in two
//   single-port-read RAMs (key and payload), each with a registered read.
//   From accept to next possible accept, the sequencer passes IDLE and then:
//     enqueue, no-op, full or empty cases: EXEC, RESP
//     dequeue: EXEC, DEQ_DATA (one RAM read), RESP
//     search: EXEC, then SCAN until the key matches or every held entry
//             (the occupancy) has been compared, one RAM entry per
//             cycle, then RESP.
//   One action is worked on at a time. A finished result moves into the
//   output register, so the next action is accepted while it waits. If the
//   receiver stalls with a result still held, the next result waits in the
//   sequencer and s_axis_tready stays low.
//   Synchronous reset empties the queue; RAM contents are not cleared.
// ----------------------------------------------------------------------------
`include "ring_queue_with_key_search_assert.svh"

module ring_queue_with_key_search #(
  parameter int QUEUE_DEPTH = rqks_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic                               clk,
  input  logic                               rst,
  // Action stream
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [rqks_pkg::S_TDATA_W-1:0]     s_axis_tdata,  // record_key, record_payload
  input  logic [rqks_pkg::ACTION_W-1:0]      s_axis_tuser,  // action
  // Result stream
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [rqks_pkg::M_TDATA_W-1:0]     m_axis_tdata,  // key_out, payload_out, occupancy
  output logic [rqks_pkg::STATUS_W-1:0]      m_axis_tuser   // status
);

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int KW = rqks_pkg::KEY_W;
  localparam int PW = rqks_pkg::PAYLOAD_W;
  localparam int PAD_W = rqks_pkg::M_TDATA_W - KW - PW - rqks_pkg::OCC_W;

  logic                 res_valid, res_ready;
  rqks_pkg::result_t    res;
  rqks_pkg::result_t    out_res;
  logic                 out_valid;

  logic                 ram_we, ram_re;
  logic [AW-1:0]        ram_waddr, ram_raddr;
  logic [KW-1:0]        ram_wkey, ram_rkey;
  logic [PW-1:0]        ram_wpay, ram_rpay;

  rqks_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (rqks_pkg::action_t'(s_axis_tuser)),
    .in_key     (s_axis_tdata[KW-1:0]),
    .in_payload (s_axis_tdata[KW+PW-1:KW]),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wkey   (ram_wkey),
    .ram_wpay   (ram_wpay),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_rkey   (ram_rkey),
    .ram_rpay   (ram_rpay)
  );

  rqks_ram #(
    .WIDTH (KW),
    .DEPTH (QUEUE_DEPTH)
  ) u_key_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wkey),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rkey)
  );

  rqks_ram #(
    .WIDTH (PW),
    .DEPTH (QUEUE_DEPTH)
  ) u_payload_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wpay),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rpay)
  );

  // Output register: loads when empty or being drained
  assign res_ready = !out_valid || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tuser  = out_res.status;
  assign m_axis_tdata  = {{PAD_W{1'b0}}, out_res.occupancy, out_res.payload, out_res.key};

endmodule

@@ sv/rqks_ram.sv @@
// ----------------------------------------------------------------------------
// rqks_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rqks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = rqks_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read; rdata holds until the next read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ sv/rqks_ctrl.sv @@
// ----------------------------------------------------------------------------
// rqks_ctrl
// Queue sequencer: head/tail/count, RAM access, in-order key scan.
// ----------------------------------------------------------------------------
`include "ring_queue_with_key_search_assert.svh"

module rqks_ctrl #(
  parameter int QUEUE_DEPTH = rqks_pkg::QUEUE_DEPTH_DEFAULT,
  localparam int AW         = $clog2(QUEUE_DEPTH)
) (
  input  logic                               clk,
  input  logic                               rst,
  // Request side
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rqks_pkg::action_t                  in_action,
  input  logic signed [rqks_pkg::KEY_W-1:0]  in_key,
  input  logic [rqks_pkg::PAYLOAD_W-1:0]     in_payload,
  // Result side
  output logic                               res_valid,
  input  logic                               res_ready,
  output rqks_pkg::result_t                  res,
  // RAM ports (key and payload stores share addresses)
  output logic                               ram_we,
  output logic [AW-1:0]                      ram_waddr,
  output logic [rqks_pkg::KEY_W-1:0]         ram_wkey,
  output logic [rqks_pkg::PAYLOAD_W-1:0]     ram_wpay,
  output logic                               ram_re,
  output logic [AW-1:0]                      ram_raddr,
  input  logic [rqks_pkg::KEY_W-1:0]         ram_rkey,
  input  logic [rqks_pkg::PAYLOAD_W-1:0]     ram_rpay
);

  localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

  rqks_pkg::state_t state, state_next;

  logic [AW-1:0] head, head_next;
  logic [AW-1:0] tail, tail_next;
  logic [AW-1:0] count, count_next;
  logic [AW-1:0] rd_pos, rd_pos_next;
  logic [AW-1:0] cmp_n, cmp_n_next;

  rqks_pkg::action_t                 req_action, req_action_next;
  logic [rqks_pkg::KEY_W-1:0]        req_key, req_key_next;
  logic [rqks_pkg::PAYLOAD_W-1:0]    req_payload, req_payload_next;

  rqks_pkg::status_t                 res_status, res_status_next;
  logic [rqks_pkg::KEY_W-1:0]        res_key, res_key_next;
  logic [rqks_pkg::PAYLOAD_W-1:0]    res_payload, res_payload_next;

  logic [AW-1:0] head_inc, tail_inc, rd_pos_inc, count_m1;
  logic [AW+rqks_pkg::OCC_W-1:0] occ_ext;

  // Ring increments
  assign head_inc   = (head   == LAST) ? '0 : head   + 1'b1;
  assign tail_inc   = (tail   == LAST) ? '0 : tail   + 1'b1;
  assign rd_pos_inc = (rd_pos == LAST) ? '0 : rd_pos + 1'b1;
  assign count_m1   = count - 1'b1;

  // Write data always comes from the latched request
  assign ram_waddr = tail;
  assign ram_wkey  = req_key;
  assign ram_wpay  = req_payload;

  // Occupancy is the low bits of the count
  assign occ_ext = {{rqks_pkg::OCC_W{1'b0}}, count};

  assign res.status    = res_status;
  assign res.key       = res_key;
  assign res.payload   = res_payload;
  assign res.occupancy = occ_ext[rqks_pkg::OCC_W-1:0];

  // Next state and outputs. Writes happen only in EXEC and reads only in
  // EXEC/SCAN after the write, so no entry is read and written together.
  always_comb begin
    state_next       = state;
    head_next        = head;
    tail_next        = tail;
    count_next       = count;
    rd_pos_next      = rd_pos;
    cmp_n_next       = cmp_n;
    req_action_next  = req_action;
    req_key_next     = req_key;
    req_payload_next = req_payload;
    res_status_next  = res_status;
    res_key_next     = res_key;
    res_payload_next = res_payload;
    ram_we           = 1'b0;
    ram_re           = 1'b0;
    ram_raddr        = head;
    in_ready         = 1'b0;
    res_valid        = 1'b0;

    unique case (state)
      rqks_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          req_action_next  = in_action;
          req_key_next     = in_key;
          req_payload_next = in_payload;
          state_next       = rqks_pkg::ST_EXEC;
        end
      end

      rqks_pkg::ST_EXEC: begin
        res_status_next  = rqks_pkg::STATUS_OK;
        res_key_next     = '0;
        res_payload_next = '0;
        state_next       = rqks_pkg::ST_RESP;
        unique case (req_action)
          rqks_pkg::ACT_ENQUEUE: begin
            if (count == LAST) begin
              res_status_next = rqks_pkg::STATUS_FULL;
            end else begin
              ram_we     = 1'b1;
              tail_next  = tail_inc;
              count_next = count + 1'b1;
            end
          end
          rqks_pkg::ACT_DEQUEUE: begin
            if (count == '0) begin
              res_status_next = rqks_pkg::STATUS_EMPTY;
            end else begin
              ram_re     = 1'b1;
              state_next = rqks_pkg::ST_DEQ_DATA;
            end
          end
          rqks_pkg::ACT_SEARCH: begin
            if (count == '0) begin
              res_status_next = rqks_pkg::STATUS_EMPTY;
            end else begin
              // Read head now, scan starts next cycle
              ram_re      = 1'b1;
              rd_pos_next = head_inc;
              cmp_n_next  = '0;
              state_next  = rqks_pkg::ST_SCAN;
            end
          end
          rqks_pkg::ACT_NOP: begin
          end
          default: begin
          end
        endcase
      end

      rqks_pkg::ST_DEQ_DATA: begin
        res_key_next     = ram_rkey;
        res_payload_next = ram_rpay;
        head_next        = head_inc;
        count_next       = count_m1;
        state_next       = rqks_pkg::ST_RESP;
      end

      // One entry compared per cycle, next read issued alongside
      rqks_pkg::ST_SCAN: begin
        if (ram_rkey == req_key) begin
          res_key_next     = ram_rkey;
          res_payload_next = ram_rpay;
          state_next       = rqks_pkg::ST_RESP;
        end else if (cmp_n == count_m1) begin
          res_status_next = rqks_pkg::STATUS_NOT_FOUND;
          state_next      = rqks_pkg::ST_RESP;
        end else begin
          ram_re      = 1'b1;
          ram_raddr   = rd_pos;
          rd_pos_next = rd_pos_inc;
          cmp_n_next  = cmp_n + 1'b1;
        end
      end

      rqks_pkg::ST_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = rqks_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = rqks_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rqks_pkg::ST_IDLE;
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      count <= count_next;
    end
  end

  // Request, scan and result holding registers
  always_ff @(posedge clk) begin
    rd_pos      <= rd_pos_next;
    cmp_n       <= cmp_n_next;
    req_action  <= req_action_next;
    req_key     <= req_key_next;
    req_payload <= req_payload_next;
    res_status  <= res_status_next;
    res_key     <= res_key_next;
    res_payload <= res_payload_next;
  end

  // Checks
  `RQKS_NEVER(a_count_max, clk, rst, count > LAST)
  `RQKS_NEVER(a_no_rw_overlap, clk, rst, ram_we && ram_re)
  `RQKS_NEVER(a_scan_bound, clk, rst, (state == rqks_pkg::ST_SCAN) && (cmp_n >= count))
  `RQKS_ASSERT(a_deq_read, clk, rst, (state == rqks_pkg::ST_DEQ_DATA) |-> $past(ram_re))

endmodule

@@ bench/ring_queue_with_key_search_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ring_queue_with_key_search_test
// Self-checking bench for the keyed ring queue. A short directed sequence
// covers empty, full-record-extreme and duplicate-key cases, then random
// traffic fills the ring to full, drains it across the wrap point and runs
// mixed traffic. A behavioral ring predicts every result; the monitor
// compares status, key, payload and occupancy per transaction.
// ----------------------------------------------------------------------------
module ring_queue_with_key_search_test;
  import rqks_pkg::*;

  localparam int RING_SLOTS   = QUEUE_DEPTH_DEFAULT;
  localparam int MAX_HELD     = RING_SLOTS - 1;
  localparam int STALL_LIMIT  = 3000;   // cycles with no transaction on either side
  localparam int QUIET_TAIL   = 120;    // last actions sent with no idling
  localparam int HOLD_AT      = 300;    // actions taken before the long output hold
  localparam int HOLD_CYCLES  = 240;
  localparam int RANDOM_TOTAL = 820;

  typedef struct {
    action_t                 act;
    logic signed [KEY_W-1:0] key;
    logic [PAYLOAD_W-1:0]    payload;
  } action_item_t;

  // Clock, reset and DUT ports
  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [S_TDATA_W-1:0]   s_axis_tdata = '0;   // record_key, record_payload
  logic [ACTION_W-1:0]    s_axis_tuser = '0;   // action
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_axis_tdata;        // key_out, payload_out, occupancy
  logic [STATUS_W-1:0]    m_axis_tuser;        // status

  always #6 clk = ~clk;

  ring_queue_with_key_search i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Stimulus and expectation stores
  action_item_t            pending_actions[$];
  result_t                 expected_results[$];
  logic signed [KEY_W-1:0] held_keys[$];        // keys the generator believes are held
  int                      actions_queued;

  // Predicted ring state
  logic [KEY_W-1:0]        key_mem [RING_SLOTS];
  logic [PAYLOAD_W-1:0]    payload_mem [RING_SLOTS];
  int                      head_slot;
  int                      tail_slot;
  int                      records_held;

  // Bookkeeping
  int  mismatches;
  int  results_seen;
  int  actions_taken;
  int  peak_held;
  int  action_count [4];
  int  status_count [4];
  bit  action_taken;
  int  send_gap;
  int  recv_gap;
  int  hold_left;
  bit  hold_done;
  int  quiet_cycles;

  function automatic bit quiet_tail();
    return pending_actions.size() < QUIET_TAIL;
  endfunction

  // Ring behavior: one result per action, state updated in place
  function automatic result_t apply_action(action_t act, logic [KEY_W-1:0] key,
                                           logic [PAYLOAD_W-1:0] payload);
    result_t r;
    int      pos;
    int      n;
    bit      hit;
    r = '0;
    r.status = STATUS_OK;
    case (act)
      ACT_ENQUEUE: begin
        if ((tail_slot + 1) % RING_SLOTS == head_slot) begin
          r.status = STATUS_FULL;
        end else begin
          key_mem[tail_slot]     = key;
          payload_mem[tail_slot] = payload;
          tail_slot = (tail_slot + 1) % RING_SLOTS;
          records_held++;
        end
      end
      ACT_DEQUEUE: begin
        if (records_held == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          r.key     = key_mem[head_slot];
          r.payload = payload_mem[head_slot];
          head_slot = (head_slot + 1) % RING_SLOTS;
          records_held--;
        end
      end
      ACT_SEARCH: begin
        if (records_held == 0) begin
          r.status = STATUS_EMPTY;
        end else begin
          // oldest match first, walking head to tail across the wrap
          pos = head_slot;
          hit = 1'b0;
          for (n = 0; n < records_held && !hit; n++) begin
            if (key_mem[pos] == key) begin
              r.key     = key_mem[pos];
              r.payload = payload_mem[pos];
              hit = 1'b1;
            end else begin
              pos = (pos + 1) % RING_SLOTS;
            end
          end
          if (!hit) r.status = STATUS_NOT_FOUND;
        end
      end
      default: ;
    endcase
    r.occupancy = OCC_W'(records_held);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [PAYLOAD_W-1:0] want,
                                 logic [PAYLOAD_W-1:0] got);
    mismatches++;
    $display("[%0t] result %0d: %s expected %h got %h", $time, results_seen, what, want, got);
  endtask

  // Queue one action and track which keys should be held
  task automatic queue_action(action_t act, logic signed [KEY_W-1:0] key,
                              logic [PAYLOAD_W-1:0] payload);
    action_item_t item;
    item.act     = act;
    item.key     = key;
    item.payload = payload;
    pending_actions.push_back(item);
    actions_queued++;
    if (act == ACT_ENQUEUE && held_keys.size() < MAX_HELD) held_keys.push_back(key);
    if (act == ACT_DEQUEUE && held_keys.size() > 0) void'(held_keys.pop_front());
  endtask

  function automatic logic [PAYLOAD_W-1:0] rand_payload();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Small signed range gives duplicate keys; extremes show up now and then
  function automatic logic signed [KEY_W-1:0] rand_key();
    case ($urandom_range(0, 11))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return 32'sd0;
      3:       return -32'sd1;
      4, 5, 6: return $urandom;
      default: return int'($urandom_range(0, 40)) - 20;
    endcase
  endfunction

  // Weighted random action; a no-op now and then
  task automatic queue_random(int enq_w, int deq_w, int srch_w);
    int                      pick;
    logic signed [KEY_W-1:0] key;
    pick = $urandom_range(0, enq_w + deq_w + srch_w + 2);
    if (pick < enq_w) begin
      queue_action(ACT_ENQUEUE, rand_key(), rand_payload());
    end else if (pick < enq_w + deq_w) begin
      queue_action(ACT_DEQUEUE, $urandom, rand_payload());
    end else if (pick < enq_w + deq_w + srch_w) begin
      if (held_keys.size() > 0 && $urandom_range(0, 9) < 6)
        key = held_keys[$urandom_range(0, held_keys.size() - 1)];
      else
        key = rand_key();
      queue_action(ACT_SEARCH, key, rand_payload());
    end else begin
      queue_action(ACT_NOP, $urandom, rand_payload());
    end
  endtask

  // Sender: offers the next action, idles in random bursts
  always @(negedge clk) begin
    if (!rst && (!s_axis_tvalid || action_taken)) begin
      action_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        s_axis_tvalid <= 1'b0;
      end else if (pending_actions.size() == 0) begin
        s_axis_tvalid <= 1'b0;
      end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
        send_gap = $urandom_range(0, 8);
        s_axis_tvalid <= 1'b0;
      end else begin
        action_item_t item;
        item = pending_actions.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= item.act;
        s_axis_tdata  <= {item.payload, item.key};
      end
    end
  end

  // Receiver: random stalls plus one long hold so the ring backs up
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && actions_taken >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_axis_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        m_axis_tready <= 1'b0;
      end else if (!quiet_tail() && $urandom_range(0, 7) == 0) begin
        recv_gap = $urandom_range(0, 8);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Monitor: predict on each action transaction, check each result transaction
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        result_t want;
        results_seen++;
        status_count[m_axis_tuser]++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, tdata low", '0, m_axis_tdata[63:0]);
        end else begin
          want = expected_results.pop_front();
          if (m_axis_tuser != want.status)
            report_mismatch("status", PAYLOAD_W'(want.status), PAYLOAD_W'(m_axis_tuser));
          if (m_axis_tdata[31:0] != want.key)
            report_mismatch("key", PAYLOAD_W'(unsigned'(want.key)),
                            PAYLOAD_W'(m_axis_tdata[31:0]));
          if (m_axis_tdata[95:32] != want.payload)
            report_mismatch("payload", want.payload, m_axis_tdata[95:32]);
          if (m_axis_tdata[102:96] != want.occupancy)
            report_mismatch("occupancy", PAYLOAD_W'(want.occupancy),
                            PAYLOAD_W'(m_axis_tdata[102:96]));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        action_taken = 1'b1;
        actions_taken++;
        action_count[s_axis_tuser]++;
        expected_results.push_back(apply_action(action_t'(s_axis_tuser),
                                                s_axis_tdata[31:0], s_axis_tdata[95:32]));
        if (records_held > peak_held) peak_held = records_held;
      end
    end
  end

  // Watchdog on cycles with no transaction on either stream
  always @(posedge clk) begin
    if (!rst) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else if (++quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  initial begin
    head_slot    = 0;
    tail_slot    = 0;
    records_held = 0;

    // Directed: empty cases, key extremes, duplicate keys, no-op, drain
    queue_action(ACT_DEQUEUE, 32'sd0, '0);
    queue_action(ACT_SEARCH, 32'sd0, '0);
    queue_action(ACT_NOP, 32'sh1234_5678, 64'hdead_beef_0bad_f00d);
    queue_action(ACT_ENQUEUE, 32'sh8000_0000, '0);
    queue_action(ACT_ENQUEUE, 32'sh7fff_ffff, '1);
    queue_action(ACT_ENQUEUE, 32'sd0, 64'h0123_4567_89ab_cdef);
    queue_action(ACT_ENQUEUE, -32'sd1, 64'haaaa_aaaa_aaaa_aaaa);
    queue_action(ACT_ENQUEUE, 32'sh7fff_ffff, 64'h5555_5555_5555_5555);
    queue_action(ACT_SEARCH, 32'sh7fff_ffff, '0);   // oldest of two matches
    queue_action(ACT_SEARCH, 32'sh8000_0000, '0);
    queue_action(ACT_SEARCH, -32'sd1, '0);
    queue_action(ACT_SEARCH, 32'sd12345, '0);       // no match
    queue_action(ACT_NOP, -32'sd1, '1);
    queue_action(ACT_DEQUEUE, 32'sd0, '0);
    queue_action(ACT_SEARCH, 32'sh8000_0000, '0);   // gone after dequeue
    repeat (4) queue_action(ACT_DEQUEUE, $urandom, rand_payload());
    queue_action(ACT_DEQUEUE, 32'sd0, '0);
    queue_action(ACT_SEARCH, 32'sd0, '0);

    // Fill to full, poke at full, drain across the wrap, then mixed traffic
    while (held_keys.size() < MAX_HELD) queue_random(70, 10, 17);
    repeat (10) queue_random(60, 0, 37);
    while (held_keys.size() > 0) queue_random(12, 68, 17);
    while (actions_queued < RANDOM_TOTAL) queue_random(42, 36, 19);

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    while (pending_actions.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (200) @(posedge clk);

    $display("covered %0d actions: enqueue %0d, dequeue %0d, search %0d, no-op %0d; peak %0d held",
             actions_taken, action_count[ACT_ENQUEUE], action_count[ACT_DEQUEUE],
             action_count[ACT_SEARCH], action_count[ACT_NOP], peak_held);
    $display("%0d results: ok %0d, full %0d, empty %0d, not found %0d; %0d mismatches",
             results_seen, status_count[STATUS_OK], status_count[STATUS_FULL],
             status_count[STATUS_EMPTY], status_count[STATUS_NOT_FOUND], mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
